// ----- rtl/core/pba_pkg.sv -----
package pba_pkg;

  // Address space and bitmap geometry
  localparam int unsigned ADDR_W     = 32;
  localparam int unsigned PAGE_SHIFT = 12;
  localparam int unsigned NUM_PAGES  = 1048576;
  localparam int unsigned WORD_BITS  = 32;
  localparam int unsigned CFG_W      = 20;

  localparam int unsigned PAGE_W     = ADDR_W - PAGE_SHIFT;
  localparam int unsigned BIT_W      = $clog2(WORD_BITS);
  localparam int unsigned NUM_WORDS  = (NUM_PAGES + WORD_BITS - 1) / WORD_BITS;
  localparam int unsigned WORD_IDX_W = $clog2(NUM_WORDS);

  // Bit index of the last valid page inside the last bitmap word
  localparam logic [BIT_W-1:0] LAST_BIT = BIT_W'((NUM_PAGES - 1) % WORD_BITS);
  localparam logic [WORD_IDX_W-1:0] LAST_WORD = WORD_IDX_W'(NUM_WORDS - 1);

  typedef enum logic [1:0] {
    OP_ALLOC = 2'd0,
    OP_LOCK  = 2'd1,
    OP_FREE  = 2'd2
  } op_e;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_SETUP,
    ST_WALK,
    ST_RESP
  } state_e;

  typedef struct packed {
    op_e               op;
    logic [ADDR_W-1:0] byte_address;
    logic [ADDR_W-1:0] byte_count;
  } pba_req_t;

  typedef struct packed {
    logic              success;
    logic [ADDR_W-1:0] page_address;
  } pba_rsp_t;

endpackage

// ----- rtl/core/pba_bitmap_ram.sv -----
module pba_bitmap_ram #(
  parameter int unsigned DEPTH = 32768,
  parameter int unsigned WIDTH = 32
) (
  input  logic                     clk_i,
  input  logic                     rd_en_i,
  input  logic [$clog2(DEPTH)-1:0] rd_addr_i,
  output logic [WIDTH-1:0]         rd_data_o,
  input  logic                     wr_en_i,
  input  logic [$clog2(DEPTH)-1:0] wr_addr_i,
  input  logic [WIDTH-1:0]         wr_data_i
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rd_data_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem[wr_addr_i] <= wr_data_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      rd_data_q <= mem[rd_addr_i];
    end
  end

  assign rd_data_o = rd_data_q;

endmodule

// ----- rtl/core/pba_engine.sv -----
module pba_engine (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              req_valid_i,
  output logic                              req_ready_o,
  input  pba_pkg::pba_req_t                 req_i,
  input  logic [pba_pkg::CFG_W-1:0]         heap_start_i,
  output logic                              rsp_valid_o,
  input  logic                              rsp_ready_i,
  output pba_pkg::pba_rsp_t                 rsp_o,
  output logic                              ram_rd_en_o,
  output logic [pba_pkg::WORD_IDX_W-1:0]    ram_rd_addr_o,
  input  logic [pba_pkg::WORD_BITS-1:0]     ram_rd_data_i,
  output logic                              ram_wr_en_o,
  output logic [pba_pkg::WORD_IDX_W-1:0]    ram_wr_addr_o,
  output logic [pba_pkg::WORD_BITS-1:0]     ram_wr_data_o
);
  import pba_pkg::*;

  localparam logic [WORD_BITS-1:0] ONES = {WORD_BITS{1'b1}};
  localparam logic [PAGE_W:0]      PAGE_LIMIT = (PAGE_W + 1)'(NUM_PAGES);

  state_e                  state_q, state_d;
  op_e                     op_q, op_d;
  logic [ADDR_W-1:0]       addr_q, addr_d;
  logic [ADDR_W-1:0]       count_q, count_d;
  logic [WORD_IDX_W-1:0]   first_word_q, first_word_d;
  logic [BIT_W-1:0]        first_bit_q, first_bit_d;
  logic [WORD_IDX_W-1:0]   end_word_q, end_word_d;
  logic [BIT_W-1:0]        last_bit_q, last_bit_d;
  logic [WORD_IDX_W-1:0]   rd_word_q, rd_word_d;
  logic                    iss_done_q, iss_done_d;
  logic                    pipe_vld_q, pipe_vld_d;
  logic [WORD_IDX_W-1:0]   pipe_word_q, pipe_word_d;
  logic                    success_q, success_d;
  logic [ADDR_W-1:0]       page_addr_q, page_addr_d;

  // Range decode
  logic [ADDR_W:0]         end_sum;
  logic [ADDR_W-1:0]       end_clip;
  logic [PAGE_W-1:0]       first_page;
  logic [PAGE_W-1:0]       last_page;
  logic [PAGE_W-1:0]       last_clip;
  logic [PAGE_W-1:0]       start_page;

  // Per-word mask and search
  logic [BIT_W-1:0]        lo_bit;
  logic [BIT_W-1:0]        hi_bit;
  logic [WORD_BITS-1:0]    span;
  logic [WORD_BITS-1:0]    free_bits;
  logic                    found;
  logic [BIT_W-1:0]        found_bit;
  logic [WORD_IDX_W+BIT_W-1:0] found_page;

  always_comb begin
    end_sum    = {1'b0, addr_q} + {1'b0, count_q} - (ADDR_W + 1)'(1);
    end_clip   = end_sum[ADDR_W] ? ONES[ADDR_W-1:0] | {ADDR_W{1'b1}} : end_sum[ADDR_W-1:0];
    first_page = addr_q[ADDR_W-1:PAGE_SHIFT];
    last_page  = end_clip[ADDR_W-1:PAGE_SHIFT];
    last_clip  = ({1'b0, last_page} >= PAGE_LIMIT) ? PAGE_W'(NUM_PAGES - 1) : last_page;
    start_page = PAGE_W'(heap_start_i);
  end

  always_comb begin
    lo_bit    = (pipe_word_q == first_word_q) ? first_bit_q : '0;
    hi_bit    = (pipe_word_q == end_word_q) ? last_bit_q : BIT_W'(WORD_BITS - 1);
    span      = (ONES << lo_bit) & (ONES >> (BIT_W'(WORD_BITS - 1) - hi_bit));
    free_bits = ~ram_rd_data_i & span;
    found     = |free_bits;
    found_bit = '0;
    for (int i = WORD_BITS - 1; i >= 0; i--) begin
      if (free_bits[i]) begin
        found_bit = BIT_W'(i);
      end
    end
    found_page = {pipe_word_q, found_bit};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_CLEAR;
      op_q         <= OP_ALLOC;
      addr_q       <= '0;
      count_q      <= '0;
      first_word_q <= '0;
      first_bit_q  <= '0;
      end_word_q   <= '0;
      last_bit_q   <= '0;
      rd_word_q    <= '0;
      iss_done_q   <= 1'b0;
      pipe_vld_q   <= 1'b0;
      pipe_word_q  <= '0;
      success_q    <= 1'b0;
      page_addr_q  <= '0;
    end else begin
      state_q      <= state_d;
      op_q         <= op_d;
      addr_q       <= addr_d;
      count_q      <= count_d;
      first_word_q <= first_word_d;
      first_bit_q  <= first_bit_d;
      end_word_q   <= end_word_d;
      last_bit_q   <= last_bit_d;
      rd_word_q    <= rd_word_d;
      iss_done_q   <= iss_done_d;
      pipe_vld_q   <= pipe_vld_d;
      pipe_word_q  <= pipe_word_d;
      success_q    <= success_d;
      page_addr_q  <= page_addr_d;
    end
  end

  always_comb begin
    state_d      = state_q;
    op_d         = op_q;
    addr_d       = addr_q;
    count_d      = count_q;
    first_word_d = first_word_q;
    first_bit_d  = first_bit_q;
    end_word_d   = end_word_q;
    last_bit_d   = last_bit_q;
    rd_word_d    = rd_word_q;
    iss_done_d   = iss_done_q;
    pipe_vld_d   = 1'b0;
    pipe_word_d  = pipe_word_q;
    success_d    = success_q;
    page_addr_d  = page_addr_q;

    req_ready_o   = 1'b0;
    rsp_valid_o   = 1'b0;
    ram_rd_en_o   = 1'b0;
    ram_rd_addr_o = rd_word_q;
    ram_wr_en_o   = 1'b0;
    ram_wr_addr_o = pipe_word_q;
    ram_wr_data_o = ram_rd_data_i;

    case (state_q)
      ST_CLEAR: begin
        // Zero one bitmap word per cycle
        ram_wr_en_o   = 1'b1;
        ram_wr_addr_o = rd_word_q;
        ram_wr_data_o = '0;
        rd_word_d     = rd_word_q + WORD_IDX_W'(1);
        if (rd_word_q == LAST_WORD) begin
          rd_word_d = '0;
          state_d   = ST_IDLE;
        end
      end

      ST_IDLE: begin
        req_ready_o = 1'b1;
        if (req_valid_i) begin
          op_d    = req_i.op;
          addr_d  = req_i.byte_address;
          count_d = req_i.byte_count;
          state_d = ST_SETUP;
        end
      end

      ST_SETUP: begin
        page_addr_d = '0;
        iss_done_d  = 1'b0;
        case (op_q)
          OP_ALLOC: begin
            success_d = 1'b0;
            if ({1'b0, start_page} >= PAGE_LIMIT) begin
              state_d = ST_RESP;
            end else begin
              first_word_d = WORD_IDX_W'(start_page >> BIT_W);
              first_bit_d  = start_page[BIT_W-1:0];
              end_word_d   = LAST_WORD;
              last_bit_d   = LAST_BIT;
              rd_word_d    = WORD_IDX_W'(start_page >> BIT_W);
              state_d      = ST_WALK;
            end
          end
          OP_LOCK, OP_FREE: begin
            success_d = 1'b1;
            if (count_q == '0 || {1'b0, first_page} >= PAGE_LIMIT) begin
              state_d = ST_RESP;
            end else begin
              first_word_d = WORD_IDX_W'(first_page >> BIT_W);
              first_bit_d  = first_page[BIT_W-1:0];
              end_word_d   = WORD_IDX_W'(last_clip >> BIT_W);
              last_bit_d   = last_clip[BIT_W-1:0];
              rd_word_d    = WORD_IDX_W'(first_page >> BIT_W);
              state_d      = ST_WALK;
            end
          end
          default: begin
            success_d = 1'b0;
            state_d   = ST_RESP;
          end
        endcase
      end

      ST_WALK: begin
        // Issue the next word read while the previous word is modified
        if (!iss_done_q) begin
          ram_rd_en_o = 1'b1;
          pipe_vld_d  = 1'b1;
          pipe_word_d = rd_word_q;
          if (rd_word_q == end_word_q) begin
            iss_done_d = 1'b1;
          end else begin
            rd_word_d = rd_word_q + WORD_IDX_W'(1);
          end
        end
        if (pipe_vld_q) begin
          case (op_q)
            OP_ALLOC: begin
              if (found) begin
                ram_wr_en_o   = 1'b1;
                ram_wr_data_o = ram_rd_data_i | (WORD_BITS'(1) << found_bit);
                success_d     = 1'b1;
                page_addr_d   = ADDR_W'({found_page, {PAGE_SHIFT{1'b0}}});
                state_d       = ST_RESP;
              end else if (pipe_word_q == end_word_q) begin
                state_d = ST_RESP;
              end
            end
            OP_LOCK: begin
              ram_wr_en_o   = 1'b1;
              ram_wr_data_o = ram_rd_data_i | span;
              if (pipe_word_q == end_word_q) begin
                state_d = ST_RESP;
              end
            end
            OP_FREE: begin
              ram_wr_en_o   = 1'b1;
              ram_wr_data_o = ram_rd_data_i & ~span;
              if (pipe_word_q == end_word_q) begin
                state_d = ST_RESP;
              end
            end
            default: begin
              state_d = ST_RESP;
            end
          endcase
        end
      end

      ST_RESP: begin
        rsp_valid_o = 1'b1;
        if (rsp_ready_i) begin
          state_d = ST_IDLE;
        end
      end

      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  assign rsp_o.success      = success_q;
  assign rsp_o.page_address = page_addr_q;

endmodule

// ----- rtl/core/page_bitmap_allocator.sv -----
// First-fit page allocator over a used-page bitmap, one bit per 4 KiB page.
// Requests arrive on the s_axis channel: tuser carries the operation
// (allocate, lock range, free range), tdata the byte address and byte count.
// Each request returns one result on m_axis: tuser is the success flag,
// tdata the byte address of the allocated page (zero for other operations).
// The cfg channel writes the heap start page; it is always ready. The user
// must write it only while no request is in flight; the block does not enforce this.
// Flow: the request is taken, the range is decoded, the bitmap words are
// read and walked, and the result is handed to the output register. Lock and
// free walk the 32-page words the range touches; allocate walks words from
// the heap start up to the first word holding a free page (up to 32768
// words). The bitmap memory, with one read and one write port, allows one
// word read-modify-write per cycle during the walk. Empty ranges and unknown
// operations skip the walk and answer straight after the range decode.
// After reset the bitmap is swept to all-free, one word per cycle, over all
// 32768 words; s_axis_tready stays low during the sweep.
// A stalled receiver holds the result in the output register; one more
// request is then taken and processed, and waits until the register drains.
module page_bitmap_allocator (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  // Request channel
  input  logic                          s_axis_tvalid,
  output logic                          s_axis_tready,
  input  logic [63:0]                   s_axis_tdata,  // [31:0] byte_address, [63:32] byte_count
  input  logic [1:0]                    s_axis_tuser,  // [1:0] operation
  // Result channel
  output logic                          m_axis_tvalid,
  input  logic                          m_axis_tready,
  output logic [31:0]                   m_axis_tdata,  // [31:0] page_address
  output logic                          m_axis_tuser,  // [0] success
  // Configuration channel
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic [pba_pkg::CFG_W-1:0]     cfg_data_i
);
  import pba_pkg::*;

  logic [CFG_W-1:0]      heap_start_q;
  pba_req_t              req;
  pba_rsp_t              rsp;
  logic                  rsp_valid;
  logic                  slot_free;
  logic                  m_valid_q;
  logic                  m_success_q;
  logic [ADDR_W-1:0]     m_addr_q;

  logic                  ram_rd_en;
  logic [WORD_IDX_W-1:0] ram_rd_addr;
  logic [WORD_BITS-1:0]  ram_rd_data;
  logic                  ram_wr_en;
  logic [WORD_IDX_W-1:0] ram_wr_addr;
  logic [WORD_BITS-1:0]  ram_wr_data;

  // Configuration register: take every transfer
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      heap_start_q <= '0;
    end else if (cfg_valid_i) begin
      heap_start_q <= cfg_data_i;
    end
  end

  // Unpack the request transfer
  assign req.op           = op_e'(s_axis_tuser);
  assign req.byte_address = s_axis_tdata[31:0];
  assign req.byte_count   = s_axis_tdata[63:32];

  pba_bitmap_ram #(
    .DEPTH (NUM_WORDS),
    .WIDTH (WORD_BITS)
  ) u_ram (
    .clk_i     (clk_i),
    .rd_en_i   (ram_rd_en),
    .rd_addr_i (ram_rd_addr),
    .rd_data_o (ram_rd_data),
    .wr_en_i   (ram_wr_en),
    .wr_addr_i (ram_wr_addr),
    .wr_data_i (ram_wr_data)
  );

  pba_engine u_engine (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .req_valid_i   (s_axis_tvalid),
    .req_ready_o   (s_axis_tready),
    .req_i         (req),
    .heap_start_i  (heap_start_q),
    .rsp_valid_o   (rsp_valid),
    .rsp_ready_i   (slot_free),
    .rsp_o         (rsp),
    .ram_rd_en_o   (ram_rd_en),
    .ram_rd_addr_o (ram_rd_addr),
    .ram_rd_data_i (ram_rd_data),
    .ram_wr_en_o   (ram_wr_en),
    .ram_wr_addr_o (ram_wr_addr),
    .ram_wr_data_o (ram_wr_data)
  );

  // Output register: load when empty or draining this cycle, else hold
  assign slot_free = !m_valid_q || m_axis_tready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_valid_q   <= 1'b0;
      m_success_q <= 1'b0;
      m_addr_q    <= '0;
    end else if (slot_free) begin
      m_valid_q <= rsp_valid;
      if (rsp_valid) begin
        m_success_q <= rsp.success;
        m_addr_q    <= rsp.page_address;
      end
    end
  end

  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = m_addr_q;
  assign m_axis_tuser  = m_success_q;

endmodule

// ----- test/page_allocation_checker.sv -----
`timescale 1ns / 1ps

module page_allocation_checker (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      req_valid_i,
  input  logic                      req_ready_i,
  input  logic [63:0]               req_data_i,    // [31:0] byte_address, [63:32] byte_count
  input  logic [1:0]                req_user_i,    // [1:0] operation
  input  logic                      rsp_valid_i,
  input  logic                      rsp_ready_i,
  input  logic [31:0]               rsp_data_i,    // [31:0] page_address
  input  logic                      rsp_user_i,    // [0] success
  input  logic                      cfg_valid_i,
  input  logic                      cfg_ready_i,
  input  logic [pba_pkg::CFG_W-1:0] cfg_data_i,
  output logic [31:0]               mismatches_o,
  output logic [31:0]               pending_o
);
  import pba_pkg::*;

  // Shadow copy of the used-page bitmap and the heap start register
  logic [WORD_BITS-1:0] page_used_q [NUM_WORDS];
  logic [CFG_W-1:0]     heap_start_q;
  pba_rsp_t             rsp_expected_q [$];
  int unsigned          mismatch_count = 0;

  task automatic report_mismatch(input string msg);
    $display("[%0t] mismatch: %s", $realtime, msg);
    mismatch_count++;
  endtask

  function automatic void set_pages(input int unsigned first, input int unsigned last,
                                    input bit used);
    int unsigned          w;
    int unsigned          lo;
    int unsigned          hi;
    logic [WORD_BITS-1:0] mask;
    for (w = first / WORD_BITS; w <= last / WORD_BITS && w < NUM_WORDS; w++) begin
      lo   = (w == first / WORD_BITS) ? first % WORD_BITS : 0;
      hi   = (w == last / WORD_BITS) ? last % WORD_BITS : WORD_BITS - 1;
      mask = ({WORD_BITS{1'b1}} << lo) & ({WORD_BITS{1'b1}} >> (WORD_BITS - 1 - hi));
      if (used) begin
        page_used_q[w] |= mask;
      end else begin
        page_used_q[w] &= ~mask;
      end
    end
  endfunction

  function automatic bit find_free_page(input int unsigned start, output int unsigned page);
    int unsigned          w;
    int unsigned          b;
    logic [WORD_BITS-1:0] free_bits;
    page = 0;
    if (start >= NUM_PAGES) return 1'b0;
    for (w = start / WORD_BITS; w < NUM_WORDS; w++) begin
      free_bits = ~page_used_q[w];
      if (w == start / WORD_BITS) free_bits &= {WORD_BITS{1'b1}} << (start % WORD_BITS);
      // drop bits past the last page in a partly filled top word
      if ((w + 1) * WORD_BITS > NUM_PAGES) begin
        free_bits &= {WORD_BITS{1'b1}} >> ((w + 1) * WORD_BITS - NUM_PAGES);
      end
      if (free_bits != '0) begin
        for (b = 0; b < WORD_BITS; b++) begin
          if (free_bits[b]) begin
            page = w * WORD_BITS + b;
            return 1'b1;
          end
        end
      end
    end
    return 1'b0;
  endfunction

  function automatic pba_rsp_t serve_request(input op_e op, input logic [ADDR_W-1:0] addr,
                                             input logic [ADDR_W-1:0] count);
    pba_rsp_t          rsp;
    int unsigned       page;
    int unsigned       first;
    int unsigned       last;
    logic [ADDR_W:0]   range_end;
    rsp = '0;
    case (op)
      OP_ALLOC: begin
        if (find_free_page(32'(heap_start_q), page)) begin
          set_pages(page, page, 1'b1);
          rsp.success      = 1'b1;
          rsp.page_address = ADDR_W'(page << PAGE_SHIFT);
        end
      end
      OP_LOCK, OP_FREE: begin
        rsp.success = 1'b1;
        if (count != '0) begin
          range_end = {1'b0, addr} + {1'b0, count} - 1'b1;
          // clip at the top byte of the address space
          if (range_end[ADDR_W]) range_end = {1'b0, {ADDR_W{1'b1}}};
          first = addr >> PAGE_SHIFT;
          last  = range_end[ADDR_W-1:0] >> PAGE_SHIFT;
          if (first < NUM_PAGES) begin
            if (last >= NUM_PAGES) last = NUM_PAGES - 1;
            set_pages(first, last, op == OP_LOCK);
          end
        end
      end
      default: ;
    endcase
    return rsp;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin : track
    pba_rsp_t got;
    pba_rsp_t want;
    if (!rst_ni) begin
      foreach (page_used_q[i]) page_used_q[i] = '0;
      heap_start_q = '0;
      rsp_expected_q.delete();
      pending_o    <= '0;
      mismatches_o <= mismatch_count;
    end else begin
      if (cfg_valid_i && cfg_ready_i) heap_start_q = cfg_data_i;
      if (rsp_valid_i && rsp_ready_i) begin
        got.success      = rsp_user_i;
        got.page_address = rsp_data_i;
        if (rsp_expected_q.size() == 0) begin
          report_mismatch($sformatf("result with none pending: success=%0b page_address=%h",
                                    got.success, got.page_address));
        end else begin
          want = rsp_expected_q.pop_front();
          if (got.success !== want.success) begin
            report_mismatch($sformatf("success %0b, predicted %0b", got.success, want.success));
          end
          if (got.page_address !== want.page_address) begin
            report_mismatch($sformatf("page_address %h, predicted %h",
                                      got.page_address, want.page_address));
          end
        end
      end
      if (req_valid_i && req_ready_i) begin
        rsp_expected_q.push_back(serve_request(op_e'(req_user_i), req_data_i[31:0],
                                               req_data_i[63:32]));
      end
      pending_o    <= rsp_expected_q.size();
      mismatches_o <= mismatch_count;
    end
  end

endmodule

// ----- test/page_bitmap_allocator_tb.sv -----
`timescale 1ns / 1ps

module page_bitmap_allocator_tb;
  import pba_pkg::*;

  // Operation code the block must answer with a failure and no side effect
  localparam logic [1:0]       OP_UNUSED   = 2'd3;
  // Longest legal silence is a full bitmap walk or the sweep after reset
  localparam int unsigned      IDLE_LIMIT  = 200000;
  localparam int unsigned      PHASES      = 7;
  localparam int unsigned      PHASE_ITEMS = 147;
  localparam logic [CFG_W-1:0] HEAP_TOP    = CFG_W'(NUM_PAGES - 1);
  localparam logic [31:0]      ALL_ONES    = 32'hFFFF_FFFF;
  localparam logic [31:0]      PAGE_BYTES  = 32'(1) << PAGE_SHIFT;

  logic             clk_i         = 1'b0;
  logic             rst_ni        = 1'b0;
  logic             s_axis_tvalid = 1'b0;
  logic             s_axis_tready;
  logic [63:0]      s_axis_tdata  = '0;   // [31:0] byte_address, [63:32] byte_count
  logic [1:0]       s_axis_tuser  = '0;   // [1:0] operation
  logic             m_axis_tvalid;
  logic             m_axis_tready = 1'b0;
  logic [31:0]      m_axis_tdata;         // [31:0] page_address
  logic             m_axis_tuser;         // [0] success
  logic             cfg_valid_i   = 1'b0;
  logic             cfg_ready_o;
  logic [CFG_W-1:0] cfg_data_i    = '0;

  logic [31:0]      mismatches;
  logic [31:0]      pending;
  logic [CFG_W-1:0] heap_mirror   = '0;   // heap start as last written, steers the ranges
  bit               no_idle       = 1'b0; // set for stretches without gaps on either side
  int unsigned      idle_cycles   = 0;

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  page_bitmap_allocator u_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_data_i    (cfg_data_i)
  );

  page_allocation_checker u_checker (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .req_valid_i  (s_axis_tvalid),
    .req_ready_i  (s_axis_tready),
    .req_data_i   (s_axis_tdata),
    .req_user_i   (s_axis_tuser),
    .rsp_valid_i  (m_axis_tvalid),
    .rsp_ready_i  (m_axis_tready),
    .rsp_data_i   (m_axis_tdata),
    .rsp_user_i   (m_axis_tuser),
    .cfg_valid_i  (cfg_valid_i),
    .cfg_ready_i  (cfg_ready_o),
    .cfg_data_i   (cfg_data_i),
    .mismatches_o (mismatches),
    .pending_o    (pending)
  );

  // Watchdog: count cycles without any transfer on any channel
  always @(posedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
        (cfg_valid_i && cfg_ready_o)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("Verification failed");
      $finish;
    end
  end

  // Result side: stall a random number of cycles before each transfer,
  // then hold ready until the block offers a result.
  initial begin : result_sink
    int unsigned stall;
    forever begin
      stall = no_idle ? 0 : $urandom_range(0, 4);
      if (stall != 0) begin
        m_axis_tready <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
      m_axis_tready <= 1'b1;
      do @(posedge clk_i); while (!m_axis_tvalid);
    end
  end

  // Offer one request after a random gap and return once it is transferred.
  // Valid stays high afterwards, so a following request with no gap keeps it
  // high rather than dropping and raising it in the same step.
  task automatic send_request(input logic [1:0] op, input logic [31:0] addr,
                              input logic [31:0] count);
    int unsigned gap;
    gap = no_idle ? 0 : $urandom_range(0, 4);
    if (gap != 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {count, addr};
    s_axis_tuser  <= op;
    do @(posedge clk_i); while (!s_axis_tready);
  endtask

  // Write the heap start only once every pending result has drained
  task automatic write_heap_start(input logic [CFG_W-1:0] value);
    s_axis_tvalid <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_data_i  <= value;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    heap_mirror = value;
  endtask

  // One random request. Most ranges fall in a window around the heap start so
  // that allocations run into locked and freed pages; a few hit the top of the
  // address space with a random length, and rarely a long free walks far.
  task automatic random_request();
    int unsigned pick;
    int unsigned base;
    int unsigned first_page;
    logic [31:0] addr;
    logic [31:0] count;
    logic [1:0]  op;
    pick  = $urandom_range(0, 199);
    addr  = $urandom();
    count = $urandom();
    op    = $urandom_range(0, 1) ? OP_LOCK : OP_FREE;
    base  = (heap_mirror > 32) ? heap_mirror - 32 : 0;
    if (pick < 70) begin
      send_request(OP_ALLOC, addr, count);
    end else if (pick < 170) begin
      first_page = base + $urandom_range(0, 255);
      if (first_page > NUM_PAGES - 1) first_page = NUM_PAGES - 1;
      addr  = {first_page[PAGE_W-1:0], addr[PAGE_SHIFT-1:0]};
      count = ($urandom_range(0, 15) == 0) ? '0 : $urandom_range(1, 40 * PAGE_BYTES);
      send_request(pick < 120 ? OP_LOCK : OP_FREE, addr, count);
    end else if (pick < 185) begin
      // end of range clipped at the top byte
      first_page = NUM_PAGES - 1 - $urandom_range(0, 63);
      addr = {first_page[PAGE_W-1:0], addr[PAGE_SHIFT-1:0]};
      send_request(op, addr, count);
    end else if (pick < 195) begin
      send_request(op, addr, $urandom_range(0, 32 * PAGE_BYTES));
    end else if (pick < 199) begin
      send_request(OP_UNUSED, addr, count);
    end else begin
      send_request(OP_FREE, addr, count);
    end
  endtask

  initial begin : stimulus
    logic [CFG_W-1:0] heap_start;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Directed part with the heap start at its reset value
    send_request(OP_ALLOC, '0, '0);                        // page zero, address zero
    send_request(OP_ALLOC, ALL_ONES, ALL_ONES);
    send_request(OP_LOCK, 32'h0000_2000, '0);              // empty range
    send_request(OP_FREE, '0, '0);
    send_request(OP_LOCK, 32'h0000_2FFF, 32'd2);           // two bytes across a page edge
    send_request(OP_ALLOC, '0, '0);
    send_request(OP_FREE, 32'h0000_1000, 32'd1);
    send_request(OP_ALLOC, '0, '0);                        // reuse the freed page
    send_request(OP_UNUSED, $urandom(), $urandom());
    send_request(OP_LOCK, 32'h0001_F000, 32'h0000_2000);   // across a bitmap word edge
    send_request(OP_LOCK, 32'hFFFF_F000, ALL_ONES);        // clipped at the top
    send_request(OP_LOCK, ALL_ONES, 32'd1);
    send_request(OP_FREE, '0, ALL_ONES);                   // whole bitmap free
    send_request(OP_LOCK, '0, ALL_ONES);                   // whole bitmap used
    send_request(OP_ALLOC, '0, '0);                        // nothing free: fails
    send_request(OP_FREE, 32'h8000_0000, ALL_ONES);        // upper half, clipped
    send_request(OP_ALLOC, '0, '0);
    send_request(OP_FREE, '0, ALL_ONES);

    // Heap start on the last page
    write_heap_start(HEAP_TOP);
    send_request(OP_ALLOC, '0, '0);
    send_request(OP_ALLOC, '0, '0);                        // top page taken: fails
    send_request(OP_FREE, 32'hFFFF_F000, PAGE_BYTES);
    send_request(OP_ALLOC, '0, '0);
    send_request(OP_UNUSED, ALL_ONES, ALL_ONES);

    // Random phases, each under its own heap start
    for (int unsigned phase = 0; phase < PHASES; phase++) begin
      case (phase)
        0:       heap_start = '0;
        1:       heap_start = HEAP_TOP;
        2:       heap_start = CFG_W'(HEAP_TOP - 63);
        6:       heap_start = CFG_W'($urandom_range(1, 4096));
        default: heap_start = CFG_W'($urandom());
      endcase
      write_heap_start(heap_start);
      no_idle = (phase % 3 == 2);
      repeat (PHASE_ITEMS) random_request();
    end

    // Drain: wait for every pending result, then a little longer for strays
    s_axis_tvalid <= 1'b0;
    no_idle = 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (40) @(posedge clk_i);
    if (mismatches == 0 && pending == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

// ----- page_bitmap_allocator.f -----
rtl/core/pba_pkg.sv
rtl/core/pba_bitmap_ram.sv
rtl/core/pba_engine.sv
rtl/core/page_bitmap_allocator.sv
test/page_allocation_checker.sv
test/page_bitmap_allocator_tb.sv
